// File: rtl/core/fsaa_pkg.sv
// fsaa_pkg: shared command, configuration and operation codes for the frame stacking store
`timescale 1ns / 1ps
package fsaa_pkg;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_ACCUM = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam int CFG_WIDTH_IDX  = 0;
   localparam int CFG_HEIGHT_IDX = 1;

   // classified operation between front and back
   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ACCUM = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_OOR   = 2'd3;   // read off the canvas

endpackage

// File: rtl/core/fsaa_queue.sv
// fsaa_queue: small fifo of classified items between front and back
`timescale 1ns / 1ps
module fsaa_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   localparam int AW = $clog2(DEPTH);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full     = cnt_ff == (AW+1)'(DEPTH);
   assign empty    = cnt_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? ((wr_ff == AW'(DEPTH-1)) ? '0 : wr_ff + 1'b1) : wr_ff;
      rd_in  = do_pop ? ((rd_ff == AW'(DEPTH-1)) ? '0 : rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) mem_ff[wr_ff] <= push_data;
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |=> !(cnt_ff > (AW+1)'(DEPTH))) else $error("queue overflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count step");
   a_empty_hold: assert property (@(posedge clock) disable iff (reset)
      (empty && !push) |=> empty) else $error("empty changed");
`endif
endmodule

// File: rtl/core/fsaa_front.sv
// fsaa_front: decodes items, checks the canvas and forms the store address
`timescale 1ns / 1ps
module fsaa_front #(
   parameter int XW = 8,
   parameter int YW = 8,
   parameter int AW = 18,
   parameter int MAX_WIDTH = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CHANNELS = 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic [1:0]    cmd,
   input  logic [7:0]    pos_x,
   input  logic [7:0]    pos_y,
   input  logic [1:0]    channel,
   input  logic [7:0]    shift_x,
   input  logic [7:0]    shift_y,
   input  logic [7:0]    pixel,
   input  logic [8:0]    cfg_width,
   input  logic [8:0]    cfg_height,
   output logic          out_valid,
   output logic [1:0]    out_op,
   output logic [AW-1:0] out_addr,
   output logic [7:0]    out_pixel
);
   logic [8:0] x, y;
   logic [12:0] wlim, hlim;
   logic on_canvas;
   logic [AW+2:0] lin;

   always_comb begin
      x = (cmd == fsaa_pkg::CMD_ACCUM) ? 9'(pos_x) + 9'(shift_x) : 9'(pos_x);
      y = (cmd == fsaa_pkg::CMD_ACCUM) ? 9'(pos_y) + 9'(shift_y) : 9'(pos_y);
      wlim = (13'(cfg_width) < 13'(MAX_WIDTH)) ? 13'(cfg_width) : 13'(MAX_WIDTH);
      hlim = (13'(cfg_height) < 13'(MAX_HEIGHT)) ? 13'(cfg_height) : 13'(MAX_HEIGHT);
      on_canvas = (13'(x) < wlim) && (13'(y) < hlim) && (3'(channel) < 3'(CHANNELS));
      lin = ((AW+3)'(y) * (AW+3)'(MAX_WIDTH) + (AW+3)'(x)) * (AW+3)'(CHANNELS)
            + (AW+3)'(channel);
      out_addr  = lin[AW-1:0];
      out_pixel = pixel;
      out_valid = 1'b0;
      out_op    = fsaa_pkg::OP_OOR;
      case (cmd)
         fsaa_pkg::CMD_CLEAR: begin
            out_valid = in_valid && on_canvas;
            out_op    = fsaa_pkg::OP_CLEAR;
         end
         fsaa_pkg::CMD_ACCUM: begin
            out_valid = in_valid && on_canvas;
            out_op    = fsaa_pkg::OP_ACCUM;
         end
         fsaa_pkg::CMD_READ: begin
            out_valid = in_valid;
            out_op    = on_canvas ? fsaa_pkg::OP_READ : fsaa_pkg::OP_OOR;
         end
         default: out_valid = 1'b0;
      endcase
   end

   logic unused;
   assign unused = clock ^ reset ^ (|XW) ^ (|YW);
endmodule

// File: rtl/core/fsaa_back.sv
// fsaa_back: store access, clearing pass, update and serial mean divider
`timescale 1ns / 1ps
module fsaa_back #(
   parameter int AW = 18,
   parameter int DEPTH = 196608,
   parameter int MAX_FRAMES = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  logic [1:0]    q_op,
   input  logic [AW-1:0] q_addr,
   input  logic [7:0]    q_pixel,
   output logic          q_pop,
   output logic          init_busy,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic [15:0]   rsp_mean_value,
   output logic [8:0]    rsp_hit_count,
   output logic          rsp_empty_res,
   output logic          rsp_out_of_range
);
   localparam logic [2:0] ST_INIT = 3'd0, ST_IDLE = 3'd1, ST_RD = 3'd2,
                          ST_EXEC = 3'd3, ST_DIV = 3'd4, ST_OUT = 3'd5;
   localparam int HW = 17;

   logic [24:0] mem [DEPTH];   // {hits, sum}
   logic [24:0] rdata_ff;
   logic [2:0] st_ff, st_in;
   logic [AW-1:0] addr_ff, addr_in;
   logic [1:0] op_ff, op_in;
   logic [7:0] pix_ff, pix_in;
   logic we;
   logic [AW-1:0] waddr;
   logic [24:0] wdata;
   logic [23:0] rem_ff, rem_in;   // dividend shift register
   logic [HW-1:0] quo_ff, quo_in;
   logic [9:0] part_ff, part_in;
   logic [4:0] bit_ff, bit_in;
   logic [15:0] mean_ff, mean_in;
   logic [8:0] hits_ff, hits_in;
   logic emp_ff, emp_in, oor_ff, oor_in, full_ff, full_in;
   logic [16:0] s;
   logic [9:0] h;
   logic [10:0] trial;

   assign init_busy = st_ff == ST_INIT;
   assign rsp_empty = !full_ff;
   assign rsp_mean_value = mean_ff;
   assign rsp_hit_count = hits_ff;
   assign rsp_empty_res = emp_ff;
   assign rsp_out_of_range = oor_ff;

   always_comb begin
      st_in = st_ff; addr_in = addr_ff; op_in = op_ff; pix_in = pix_ff;
      rem_in = rem_ff; quo_in = quo_ff; part_in = part_ff; bit_in = bit_ff;
      mean_in = mean_ff; hits_in = hits_ff; emp_in = emp_ff; oor_in = oor_ff;
      full_in = full_ff && !rsp_pop;
      q_pop = 1'b0; we = 1'b0; waddr = addr_ff; wdata = '0;
      s = '0; h = '0; trial = '0;
      case (st_ff)
         ST_INIT: begin
            we = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == AW'(DEPTH-1)) begin
               st_in = ST_IDLE;
               addr_in = '0;
            end
         end
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop = 1'b1;
               addr_in = q_addr; op_in = q_op; pix_in = q_pixel;
               st_in = ST_RD;
            end
         end
         ST_RD: st_in = ST_EXEC;
         ST_EXEC: begin
            case (op_ff)
               fsaa_pkg::OP_CLEAR: begin
                  we = 1'b1;
                  st_in = ST_IDLE;
               end
               fsaa_pkg::OP_ACCUM: begin
                  we = 1'b1;
                  s = 17'(rdata_ff[15:0]) + 17'(pix_ff);
                  h = 10'(rdata_ff[24:16]);
                  if (pix_ff != 8'd0 && h < 10'(MAX_FRAMES)) h = h + 1'b1;
                  wdata = {h[8:0], s[16] ? 16'hFFFF : s[15:0]};
                  st_in = ST_IDLE;
               end
               fsaa_pkg::OP_READ: begin
                  // wait here while an earlier result is still held
                  if (!full_in) begin
                     hits_in = rdata_ff[24:16];
                     oor_in = 1'b0;
                     emp_in = rdata_ff[24:16] == 9'd0;
                     rem_in = {rdata_ff[15:0], 8'd0};
                     quo_in = '0; part_in = '0; bit_in = '0;
                     mean_in = '0;
                     st_in = emp_in ? ST_OUT : ST_DIV;
                  end
               end
               default: begin
                  if (!full_in) begin
                     hits_in = '0; oor_in = 1'b1; emp_in = 1'b1; mean_in = '0;
                     st_in = ST_OUT;
                  end
               end
            endcase
         end
         ST_DIV: begin
            // one quotient bit a cycle, restoring
            trial = {part_ff, rem_ff[23]} - 11'(hits_ff);
            rem_in = {rem_ff[22:0], 1'b0};
            if (!trial[10]) begin
               part_in = trial[9:0];
               quo_in = {quo_ff[HW-2:0], 1'b1};
            end else begin
               part_in = {part_ff[8:0], rem_ff[23]};
               quo_in = {quo_ff[HW-2:0], 1'b0};
            end
            bit_in = bit_ff + 1'b1;
            if (bit_ff == 5'd23) begin
               mean_in = (quo_in[HW-1:16] != '0) ? 16'hFFFF : quo_in[15:0];
               st_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!full_in) begin
               full_in = 1'b1;
               st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_INIT;
         addr_ff <= '0;
         full_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         addr_ff <= addr_in;
         full_ff <= full_in;
      end
      op_ff <= op_in; pix_ff <= pix_in; rem_ff <= rem_in; quo_ff <= quo_in;
      part_ff <= part_in; bit_ff <= bit_in; mean_ff <= mean_in;
      hits_ff <= hits_in; emp_ff <= emp_in; oor_ff <= oor_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[addr_ff];
   end

`ifndef ASSERT_OFF
   a_no_pop_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !q_pop) else $error("item taken during clearing pass");
   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (full_ff && !rsp_pop) |=> $stable(mean_ff) && $stable(hits_ff)) else
      $error("result overwritten");
   a_empty_mean_zero: assert property (@(posedge clock) disable iff (reset)
      (full_ff && emp_ff) |-> mean_ff == 16'd0) else $error("empty with mean");
`endif
endmodule

// File: rtl/core/frame_stack_accumulate_average_top.sv
// frame_stack_accumulate_average_top: per-pixel stacking store with mean read-out
`timescale 1ns / 1ps
// Keeps a running sum and a nonzero-hit count per (column, row, channel) in
// one single-port memory. After reset a clearing pass writes zero to every
// entry, one entry a cycle; full stays high meanwhile. The front decodes
// each item, checks it against the canvas and forms the address in the
// cycle it is pushed; off-canvas clear and accumulate items are dropped
// there. A four entry queue feeds the back, which handles one item at a
// time: it pops the item, registers the memory read and then executes it;
// a read with a nonzero count also runs the bit-serial mean divider before
// the result goes out. The result register lets clear and accumulate items
// go on while a result waits; a read holds in the back until the waiting
// result is taken. Configuration writes take effect at once and are meant
// for idle periods.
module frame_stack_accumulate_average_top #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int CHANNELS   = 3,
   parameter int MAX_FRAMES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [1:0]  req_cmd,
   input  logic [7:0]  req_pos_x,
   input  logic [7:0]  req_pos_y,
   input  logic [1:0]  req_channel,
   input  logic [7:0]  req_shift_x,
   input  logic [7:0]  req_shift_y,
   input  logic [7:0]  req_pixel,
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_mean_value,
   output logic [8:0]  rsp_hit_count,
   output logic        rsp_empty_res,
   output logic        rsp_out_of_range,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [8:0]  csr_data
);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
   localparam int AW = $clog2(DEPTH);
   localparam int QW = 2 + AW + 8;

   logic [8:0] width_ff, height_ff;
   logic f_valid, q_full, q_empty, q_pop, init_busy;
   logic [1:0] f_op;
   logic [AW-1:0] f_addr;
   logic [7:0] f_pix;
   logic [QW-1:0] q_out;

   // canvas registers
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 9'd256;
         height_ff <= 9'd256;
      end else if (csr_we) begin
         if (csr_index == 1'(fsaa_pkg::CFG_WIDTH_IDX)) width_ff <= csr_data;
         else height_ff <= csr_data;
      end
   end

   // stall while the store is being cleared or the queue is full
   assign full = q_full || init_busy;

   fsaa_front #(.XW(8), .YW(8), .AW(AW), .MAX_WIDTH(MAX_WIDTH),
                .MAX_HEIGHT(MAX_HEIGHT), .CHANNELS(CHANNELS)) u_front (
      .clock, .reset, .in_valid(push && !full), .cmd(req_cmd), .pos_x(req_pos_x),
      .pos_y(req_pos_y), .channel(req_channel), .shift_x(req_shift_x),
      .shift_y(req_shift_y), .pixel(req_pixel), .cfg_width(width_ff),
      .cfg_height(height_ff), .out_valid(f_valid), .out_op(f_op),
      .out_addr(f_addr), .out_pixel(f_pix)
   );

   fsaa_queue #(.DATA_W(QW), .DEPTH(4)) u_queue (
      .clock, .reset, .push(f_valid), .push_data({f_op, f_addr, f_pix}),
      .full(q_full), .pop(q_pop), .pop_data(q_out), .empty(q_empty)
   );

   fsaa_back #(.AW(AW), .DEPTH(DEPTH), .MAX_FRAMES(MAX_FRAMES)) u_back (
      .clock, .reset, .q_empty, .q_op(q_out[QW-1:QW-2]), .q_addr(q_out[AW+7:8]),
      .q_pixel(q_out[7:0]), .q_pop, .init_busy, .rsp_empty(empty), .rsp_pop(pop),
      .rsp_mean_value, .rsp_hit_count, .rsp_empty_res, .rsp_out_of_range
   );

`ifndef ASSERT_OFF
   a_full_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> full) else $error("input open during clearing pass");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty && $stable(rsp_mean_value)) else
      $error("result dropped");
   a_cfg_width: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == 1'b0) |=> width_ff == $past(csr_data)) else
      $error("width write lost");
`endif
endmodule

// File: tb/sv/tb_frame_stack_accumulate_average_top.sv
// tb_frame_stack_accumulate_average_top: self-checking testbench for the frame stacking store
`timescale 1ns / 1ps
module tb_frame_stack_accumulate_average_top;

   localparam int MAX_W   = 256;
   localparam int MAX_H   = 256;
   localparam int NCH     = 3;
   localparam int NFRAMES = 256;
   localparam int DEPTH   = MAX_W * MAX_H * NCH;
   localparam int CYCLE_LIMIT = 1500000;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] pos_x;
      logic [7:0] pos_y;
      logic [1:0] channel;
      logic [7:0] shift_x;
      logic [7:0] shift_y;
      logic [7:0] pixel;
   } stack_item_type;

   typedef struct packed {
      logic [15:0] mean_value;
      logic [8:0]  hit_count;
      logic        empty_res;
      logic        out_of_range;
   } mean_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic [1:0]  req_cmd = '0;
   logic [7:0]  req_pos_x = '0;
   logic [7:0]  req_pos_y = '0;
   logic [1:0]  req_channel = '0;
   logic [7:0]  req_shift_x = '0;
   logic [7:0]  req_shift_y = '0;
   logic [7:0]  req_pixel = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [15:0] rsp_mean_value;
   logic [8:0]  rsp_hit_count;
   logic        rsp_empty_res;
   logic        rsp_out_of_range;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = '0;
   logic [8:0]  csr_data = '0;

   frame_stack_accumulate_average_top DUT (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_cmd(req_cmd), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_channel(req_channel), .req_shift_x(req_shift_x),
      .req_shift_y(req_shift_y), .req_pixel(req_pixel),
      .empty(empty), .pop(pop), .rsp_mean_value(rsp_mean_value),
      .rsp_hit_count(rsp_hit_count), .rsp_empty_res(rsp_empty_res),
      .rsp_out_of_range(rsp_out_of_range),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   // shadow of the stacking store and the canvas registers
   logic [15:0]  sum_store [DEPTH];
   logic [8:0]   hits_store [DEPTH];
   logic [8:0]   canvas_w;
   logic [8:0]   canvas_h;

   stack_item_type  pending_items [$];
   mean_result_type expected_means [$];
   int           error_count = 0;
   int           cycle_count = 0;
   bit           sink_hold = 1'b0;   // long receiver hold-off in progress
   bit           sink_hold_req = 1'b0;

   // address lookup against the canvas; returns -1 when off canvas
   function automatic int canvas_index(int x, int y, int ch);
      int w;
      int h;
      w = (canvas_w < MAX_W) ? canvas_w : MAX_W;
      h = (canvas_h < MAX_H) ? canvas_h : MAX_H;
      if (x >= w || y >= h || ch >= NCH) return -1;
      return (y * MAX_W + x) * NCH + ch;
   endfunction

   // apply one accepted item to the shadow store, queue a mean if it is a read
   task automatic stack_apply(stack_item_type it);
      int idx;
      int s;
      longint m;
      mean_result_type r;
      case (it.cmd)
         fsaa_pkg::CMD_CLEAR: begin
            idx = canvas_index(it.pos_x, it.pos_y, it.channel);
            if (idx >= 0) begin
               sum_store[idx] = '0;
               hits_store[idx] = '0;
            end
         end
         fsaa_pkg::CMD_ACCUM: begin
            idx = canvas_index(int'(it.pos_x) + int'(it.shift_x),
                               int'(it.pos_y) + int'(it.shift_y), it.channel);
            if (idx >= 0) begin
               s = int'(sum_store[idx]) + int'(it.pixel);
               sum_store[idx] = (s > 65535) ? 16'hFFFF : s[15:0];
               if (it.pixel != 0 && hits_store[idx] < NFRAMES)
                  hits_store[idx] = hits_store[idx] + 9'd1;
            end
         end
         fsaa_pkg::CMD_READ: begin
            r = '{mean_value: 16'd0, hit_count: 9'd0, empty_res: 1'b1, out_of_range: 1'b1};
            idx = canvas_index(it.pos_x, it.pos_y, it.channel);
            if (idx >= 0) begin
               r.out_of_range = 1'b0;
               r.hit_count = hits_store[idx];
               if (hits_store[idx] != 0) begin
                  r.empty_res = 1'b0;
                  m = (longint'(sum_store[idx]) << 8) / hits_store[idx];
                  r.mean_value = (m > 65535) ? 16'hFFFF : m[15:0];
               end
            end
            expected_means.push_back(r);
         end
         default: ;   // command 3 is ignored
      endcase
   endtask

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_frame_stack_accumulate_average_top: done, errors");
         $finish;
      end
   end

   // acceptance is sampled at the rising edge and consumed by the driver
   logic full_q = 1'b1;
   always @(posedge clock) begin
      full_q <= full;
      if (!reset && push && !full) stack_apply(pending_items[0]);
   end

   // driver: offers items from the pending queue with random gaps
   int  gap_left = 0;
   bit  src_pause = 1'b0;
   always @(negedge clock) begin
      if (!reset) begin
         if (push && !full_q) void'(pending_items.pop_front());
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            push <= 1'b0;
         end else if (pending_items.size() > 0 && !src_pause) begin
            {req_cmd, req_pos_x, req_pos_y, req_channel,
             req_shift_x, req_shift_y, req_pixel} <= pending_items[0];
            push <= 1'b1;
            if ($urandom_range(0, 5) == 0)
               gap_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                         : $urandom_range(1, 3);
         end else begin
            push <= 1'b0;
         end
      end
   end

   // monitor: checks every popped mean against the oldest expectation
   int hold_left = 0;
   always @(posedge clock) begin
      mean_result_type exp_r;
      if (!reset && pop && !empty) begin
         if (expected_means.size() == 0) begin
            $error("unexpected result: mean %0d hits %0d", rsp_mean_value, rsp_hit_count);
            error_count++;
         end else begin
            exp_r = expected_means.pop_front();
            if (rsp_mean_value !== exp_r.mean_value) begin
               $error("mean_value exp %0d got %0d", exp_r.mean_value, rsp_mean_value);
               error_count++;
            end
            if (rsp_hit_count !== exp_r.hit_count) begin
               $error("hit_count exp %0d got %0d", exp_r.hit_count, rsp_hit_count);
               error_count++;
            end
            if (rsp_empty_res !== exp_r.empty_res) begin
               $error("empty_res exp %0d got %0d", exp_r.empty_res, rsp_empty_res);
               error_count++;
            end
            if (rsp_out_of_range !== exp_r.out_of_range) begin
               $error("out_of_range exp %0d got %0d", exp_r.out_of_range, rsp_out_of_range);
               error_count++;
            end
         end
      end
   end

   // receiver: random pop with short stalls, plus one long hold-off
   always @(negedge clock) begin
      if (sink_hold_req && !sink_hold) begin
         sink_hold <= 1'b1;
         hold_left <= 1500;
         pop <= 1'b0;
      end else if (sink_hold) begin
         if (hold_left == 0) sink_hold <= 1'b0;
         else hold_left <= hold_left - 1;
         pop <= 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
         pop <= 1'b1;
      end else begin
         pop <= ($urandom_range(0, 30) == 0) ? 1'b0 : ($urandom_range(0, 1) == 1);
      end
   end

   // wait for the driver to drain and the results to arrive, then settle
   task automatic drain_all();
      while (pending_items.size() > 0 || push) @(posedge clock);
      while (expected_means.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_canvas(int idx, int value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx[0:0];
      csr_data <= value[8:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == fsaa_pkg::CFG_WIDTH_IDX) canvas_w = value[8:0];
      else canvas_h = value[8:0];
   endtask

   function automatic stack_item_type make_item(logic [1:0] c, int x, int y, int ch,
                                                int sx, int sy, int p);
      stack_item_type it;
      it = '{cmd: c, pos_x: x[7:0], pos_y: y[7:0], channel: ch[1:0],
             shift_x: sx[7:0], shift_y: sy[7:0], pixel: p[7:0]};
      return it;
   endfunction

   // random phase: mostly accumulates onto a window of the given span, mixed with reads, clears and noise
   task automatic random_phase(int n_items, int span);
      stack_item_type it;
      int k;
      int x;
      int y;
      for (k = 0; k < n_items; k++) begin
         x = $urandom_range(0, span);
         y = $urandom_range(0, span);
         case ($urandom_range(0, 19))
            0:       it = make_item(fsaa_pkg::CMD_CLEAR, x, y, $urandom_range(0, 3),
                                    0, 0, 0);
            1, 2:    it = stack_item_type'(44'({$urandom(), $urandom()}));   // noise
            3, 4, 5, 6, 7, 8:
                     it = make_item(fsaa_pkg::CMD_READ, x, y, $urandom_range(0, 2),
                                    0, 0, 0);
            9:       it = make_item(fsaa_pkg::CMD_ACCUM, $urandom_range(0, 255),
                                    $urandom_range(0, 255),
                                    $urandom_range(0, 3), $urandom_range(0, 255),
                                    $urandom_range(0, 255), $urandom_range(0, 255));
            default: it = make_item(fsaa_pkg::CMD_ACCUM, x / 2, y / 2, $urandom_range(0, 2),
                                    x - x / 2, y - y / 2,
                                    ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 255));
         endcase
         pending_items.push_back(it);
      end
   endtask

   initial begin
      int k;
      foreach (sum_store[i]) begin
         sum_store[i] = '0;
         hits_store[i] = '0;
      end
      canvas_w = 9'd256;
      canvas_h = 9'd256;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // clearing pass after reset keeps full high; the driver waits on it

      // directed: extremes, every command, off-canvas and zero-pixel items
      pending_items.push_back(make_item(fsaa_pkg::CMD_READ, 0, 0, 0, 0, 0, 0));
      pending_items.push_back(make_item(fsaa_pkg::CMD_ACCUM, 255, 255, 2, 0, 0, 255));
      pending_items.push_back(make_item(fsaa_pkg::CMD_READ, 255, 255, 2, 0, 0, 0));
      // past edge
      pending_items.push_back(make_item(fsaa_pkg::CMD_ACCUM, 200, 200, 1, 255, 255, 9));
      // bad channel
      pending_items.push_back(make_item(fsaa_pkg::CMD_ACCUM, 1, 2, 3, 0, 0, 7));
      pending_items.push_back(make_item(fsaa_pkg::CMD_READ, 3, 3, 3, 0, 0, 0));
      // zero pixel
      pending_items.push_back(make_item(fsaa_pkg::CMD_ACCUM, 0, 0, 0, 4, 5, 0));
      pending_items.push_back(make_item(fsaa_pkg::CMD_READ, 4, 5, 0, 0, 0, 0));
      pending_items.push_back(make_item(2'd3, 255, 255, 3, 255, 255, 255));    // ignored
      for (k = 0; k < 8; k++)
         pending_items.push_back(make_item(fsaa_pkg::CMD_ACCUM, 1, 1, 1, 0, 0, 1 + 37 * k));
      pending_items.push_back(make_item(fsaa_pkg::CMD_READ, 1, 1, 1, 0, 0, 0));
      pending_items.push_back(make_item(fsaa_pkg::CMD_CLEAR, 1, 1, 1, 0, 0, 0));
      pending_items.push_back(make_item(fsaa_pkg::CMD_READ, 1, 1, 1, 0, 0, 0));
      pending_items.push_back(make_item(fsaa_pkg::CMD_CLEAR, 255, 255, 3, 0, 0, 0));
      drain_all();

      // count and sum saturation on one entry: 300 adds of 255
      for (k = 0; k < 300; k++)
         pending_items.push_back(make_item(fsaa_pkg::CMD_ACCUM, 7, 7, 0, 0, 0, 255));
      pending_items.push_back(make_item(fsaa_pkg::CMD_READ, 7, 7, 0, 0, 0, 0));
      // long receiver hold-off while the sender keeps offering
      sink_hold_req = 1'b1;
      random_phase(120, 15);
      wait (sink_hold);
      sink_hold_req = 1'b0;
      drain_all();

      // sender pause until every result is in, then small canvas
      write_canvas(fsaa_pkg::CFG_WIDTH_IDX, 1);
      write_canvas(fsaa_pkg::CFG_HEIGHT_IDX, 1);
      random_phase(150, 3);
      drain_all();
      write_canvas(fsaa_pkg::CFG_WIDTH_IDX, 0);
      random_phase(60, 3);
      drain_all();
      write_canvas(fsaa_pkg::CFG_WIDTH_IDX, 511);
      write_canvas(fsaa_pkg::CFG_HEIGHT_IDX, 0);
      random_phase(60, 3);
      drain_all();
      write_canvas(fsaa_pkg::CFG_WIDTH_IDX, 12);
      write_canvas(fsaa_pkg::CFG_HEIGHT_IDX, 9);
      random_phase(250, 15);
      drain_all();
      write_canvas(fsaa_pkg::CFG_WIDTH_IDX, 256);
      write_canvas(fsaa_pkg::CFG_HEIGHT_IDX, 300);
      random_phase(150, 255);
      random_phase(150, 10);
      drain_all();

      if (error_count == 0)
         $display("tb_frame_stack_accumulate_average_top: done, clean");
      else
         $display("tb_frame_stack_accumulate_average_top: done, errors");
      $finish;
   end
endmodule

// File: filelist.f
rtl/core/fsaa_pkg.sv
rtl/core/fsaa_queue.sv
rtl/core/fsaa_front.sv
rtl/core/fsaa_back.sv
rtl/core/frame_stack_accumulate_average_top.sv
tb/sv/tb_frame_stack_accumulate_average_top.sv
